>>> design/mh_tpc_trellis_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the TPC trellis decoder
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MH_TPC_TRELLIS_DECODER_ASSERT_SVH
`define MH_TPC_TRELLIS_DECODER_ASSERT_SVH

// Condition must hold at every edge.
`define MHTPC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mhtpc assertion failed");

// Antecedent in this cycle requires consequent in this cycle.
`define MHTPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhtpc assertion failed");

// Antecedent in this cycle requires consequent in the next cycle.
`define MHTPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhtpc assertion failed");

`endif

>>> design/mhtpc_pkg.sv
// ----------------------------------------------------------------------------
// mhtpc_pkg
// Types, tables and constants shared by the TPC trellis decoder modules.
// ----------------------------------------------------------------------------
package mhtpc_pkg;

    localparam int GROUP_BYTES = 6;
    localparam int GROUPS      = 4;
    localparam int KEPT_BYTES  = 10;
    localparam int STORED      = 7;

    localparam logic [2:0] DEC_LAST = 3'(GROUP_BYTES - 1);
    localparam logic [1:0] GRP_LAST = 2'(GROUPS - 1);

    // Entry: bit 3 valid, bits 2:1 next state, bit 0 decoded bit.
    // Indexed by {state, pair}.
    localparam logic [3:0] TRELLIS_TABLE [16] = '{
        4'h8, 4'h0, 4'hD, 4'h0,
        4'h0, 4'hC, 4'h0, 4'h9,
        4'hF, 4'h0, 4'hA, 4'h0,
        4'h0, 4'hB, 4'h0, 4'hE
    };

    localparam logic [7:0] WHITEN [KEPT_BYTES] = '{
        8'hC0, 8'h6D, 8'h3F, 8'h99, 8'h38, 8'h6A, 8'h29, 8'h52, 8'hB6, 8'h64
    };

    typedef struct packed {
        logic [7:0] symbol_byte;
        logic       frame_start;
    } sym_t;

    typedef struct packed {
        logic       decode_error;
        logic [2:0] subframe_idx;
        logic [3:0] slot_idx;
        logic [6:0] parade_idx;
        logic [3:0] starting_group;
        logic [2:0] groups_minus_one;
        logic [7:0] rs_and_block_modes;
        logic [7:0] outer_code_modes;
        logic [4:0] fic_ver;
        logic [3:0] continuity_counter;
        logic [4:0] total_groups;
        logic [4:0] protocol_version;
    } hdr_t;

    typedef struct packed {
        logic [1:0] next_state;
        logic [3:0] nibble;
        logic       error;
    } trellis_out_t;

endpackage

>>> design/mh_tpc_trellis_decoder.sv
// ----------------------------------------------------------------------------
// mh_tpc_trellis_decoder
// Decodes the 24 symbol bytes of a transmission parameter channel frame
// and reports the parsed header.
// ----------------------------------------------------------------------------
// Input channel sym (sym_valid/sym_ready) carries one symbol byte per request
// with frame_start marking the first byte of a frame. Output channel hdr
// (hdr_valid/hdr_ready) carries one header request after the 24th byte of
// a frame; bytes past the 24th without a new frame_start are dropped.
// A symbol request is captured in an input register and decoded from it;
// the 24th byte's decode loads the result register that drives hdr_valid.
// One byte is accepted every cycle unless a held header stalls. The per-byte
// path is a 4-step trellis table walk plus the group bit-plane merge.
// When hdr_ready is low with a header pending, the input register holds
// its byte and sym_ready drops once that register is full; no request is
// lost. Reset clears trellis states, byte position, the error flag and
// both valid flags; the first byte after reset counts as byte 0.
// ----------------------------------------------------------------------------
`include "mh_tpc_trellis_decoder_assert.svh"

module mh_tpc_trellis_decoder
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sym_valid,
    output logic               sym_ready,
    input  mhtpc_pkg::sym_t    sym,
    output logic               hdr_valid,
    input  logic               hdr_ready,
    output mhtpc_pkg::hdr_t    hdr
);

    logic                  stage_valid_reg;
    mhtpc_pkg::sym_t       stage_reg;
    logic                  res_valid_reg;
    mhtpc_pkg::hdr_t       res_reg;
    mhtpc_pkg::hdr_t       res_next;

    logic [1:0]            tstate_reg [mhtpc_pkg::GROUP_BYTES];
    logic [3:0]            nib_reg    [mhtpc_pkg::GROUP_BYTES];
    logic [7:0]            param_reg  [mhtpc_pkg::STORED];
    logic [2:0]            dec_reg;
    logic [1:0]            grp_reg;
    logic                  done_reg;
    logic                  err_reg;

    logic                  advance;
    logic                  fire;
    logic                  fs;
    logic [2:0]            cur_dec;
    logic [1:0]            cur_grp;
    logic                  cur_done;
    logic                  cur_err;
    logic [1:0]            cur_state;
    logic                  take;
    logic                  last;
    logic                  err_next;
    logic [2:0]            cur_slot;
    logic [3:0]            view [mhtpc_pkg::GROUP_BYTES];
    logic [23:0]           merged;
    logic [7:0]            mbyte [3];
    mhtpc_pkg::trellis_out_t tr;

    assign advance   = !res_valid_reg || hdr_ready;
    assign sym_ready = !stage_valid_reg || advance;
    assign fire      = stage_valid_reg && advance;

    assign fs        = stage_reg.frame_start;
    assign cur_dec   = fs ? 3'd0 : dec_reg;
    assign cur_grp   = fs ? 2'd0 : grp_reg;
    assign cur_done  = fs ? 1'b0 : done_reg;
    assign cur_err   = fs ? 1'b0 : err_reg;
    assign cur_state = fs ? 2'd0 : tstate_reg[dec_reg];
    assign take      = !cur_done;
    assign last      = take && (cur_dec == mhtpc_pkg::DEC_LAST)
                       && (cur_grp == mhtpc_pkg::GRP_LAST);
    assign err_next  = cur_err || tr.error;

    mhtpc_trellis_unit u_trellis
    (
        .state  (cur_state),
        .symbol (stage_reg.symbol_byte),
        .result (tr)
    );

    // nibble of decoder j lands in slot (j+2) mod 6
    assign cur_slot = (cur_dec < 3'd4) ? cur_dec + 3'd2 : cur_dec - 3'd4;

    always_comb
    begin
        for (int m = 0; m < mhtpc_pkg::GROUP_BYTES; m++)
        begin
            view[m] = (cur_slot == 3'(m)) ? tr.nibble : nib_reg[m];
        end
        // bit-plane interleave: bit 3 of slots 0..5 first, MSB first
        for (int b = 0; b < 4; b++)
        begin
            for (int m = 0; m < mhtpc_pkg::GROUP_BYTES; m++)
            begin
                merged[23 - (3 - b) * mhtpc_pkg::GROUP_BYTES - m] = view[m][b];
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            mbyte[k] = merged[23 - 8 * k -: 8];
        end
    end

    always_comb
    begin
        logic [7:0] p9;
        p9 = mbyte[0] ^ mhtpc_pkg::WHITEN[9];
        res_next = '0;
        if (err_next)
        begin
            res_next.decode_error = 1'b1;
        end
        else
        begin
            res_next.subframe_idx       = param_reg[0][7:5];
            res_next.slot_idx           = param_reg[0][4:1];
            res_next.parade_idx         = {param_reg[0][0], param_reg[1][7:2]};
            res_next.starting_group     = {param_reg[1][1:0], param_reg[2][7:6]};
            res_next.groups_minus_one   = param_reg[2][5:3];
            res_next.rs_and_block_modes = param_reg[3];
            res_next.outer_code_modes   = param_reg[4];
            res_next.fic_ver            = param_reg[5][7:3];
            res_next.continuity_counter = {param_reg[5][2:0], param_reg[6][7]};
            res_next.total_groups       = param_reg[6][6:2];
            res_next.protocol_version   = p9[4:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
            dec_reg         <= 3'd0;
            grp_reg         <= 2'd0;
            done_reg        <= 1'b0;
            err_reg         <= 1'b0;
            for (int i = 0; i < mhtpc_pkg::GROUP_BYTES; i++)
            begin
                tstate_reg[i] <= 2'd0;
            end
        end
        else
        begin
            if (sym_ready)
            begin
                stage_valid_reg <= sym_valid;
            end

            if (fire && last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (hdr_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                for (int i = 0; i < mhtpc_pkg::GROUP_BYTES; i++)
                begin
                    if (take && cur_dec == 3'(i))
                    begin
                        tstate_reg[i] <= tr.next_state;
                    end
                    else if (fs)
                    begin
                        tstate_reg[i] <= 2'd0;
                    end
                end
                if (take)
                begin
                    err_reg <= err_next;
                    if (cur_dec == mhtpc_pkg::DEC_LAST)
                    begin
                        dec_reg <= 3'd0;
                        if (cur_grp == mhtpc_pkg::GRP_LAST)
                        begin
                            grp_reg  <= cur_grp;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            grp_reg  <= cur_grp + 2'd1;
                            done_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        dec_reg  <= cur_dec + 3'd1;
                        grp_reg  <= cur_grp;
                        done_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (sym_ready && sym_valid)
        begin
            stage_reg <= sym;
        end
        if (fire && last)
        begin
            res_reg <= res_next;
        end
        if (fire && take)
        begin
            nib_reg[cur_slot] <= tr.nibble;
            if (cur_dec == mhtpc_pkg::DEC_LAST)
            begin
                case (cur_grp)
                    2'd0:
                    begin
                        param_reg[0] <= mbyte[0] ^ mhtpc_pkg::WHITEN[0];
                        param_reg[1] <= mbyte[1] ^ mhtpc_pkg::WHITEN[1];
                        param_reg[2] <= mbyte[2] ^ mhtpc_pkg::WHITEN[2];
                    end
                    2'd1:
                    begin
                        param_reg[3] <= mbyte[0] ^ mhtpc_pkg::WHITEN[3];
                        param_reg[4] <= mbyte[1] ^ mhtpc_pkg::WHITEN[4];
                        param_reg[5] <= mbyte[2] ^ mhtpc_pkg::WHITEN[5];
                    end
                    2'd2:
                    begin
                        param_reg[6] <= mbyte[0] ^ mhtpc_pkg::WHITEN[6];
                    end
                    default:
                    begin
                        // last group feeds the header straight from the merge
                    end
                endcase
            end
        end
    end

    assign hdr_valid = res_valid_reg;
    assign hdr       = res_reg;

    `MHTPC_ASSERT_ALWAYS(a_dec_range, dec_reg <= mhtpc_pkg::DEC_LAST)
    `MHTPC_ASSERT_NOW(a_err_zero, res_valid_reg && res_reg.decode_error,
        res_reg.slot_idx == 4'd0 && res_reg.parade_idx == 7'd0 && res_reg.protocol_version == 5'd0)
    `MHTPC_ASSERT_NEXT(a_done_hold, fire && !fs && done_reg,
        done_reg && $stable(dec_reg) && $stable(err_reg))
    `MHTPC_ASSERT_NEXT(a_header_out, fire && last, hdr_valid)

endmodule

>>> design/mhtpc_trellis_unit.sv
// ----------------------------------------------------------------------------
// mhtpc_trellis_unit
// Hard-decision 4-state trellis step over the four pairs of one symbol byte.
// ----------------------------------------------------------------------------
module mhtpc_trellis_unit
(
    input  logic [1:0]                 state,
    input  logic [7:0]                 symbol,
    output mhtpc_pkg::trellis_out_t    result
);

    always_comb
    begin
        logic [1:0] st;
        logic [3:0] nib;
        logic       err;
        logic [3:0] entry;
        st  = state;
        nib = 4'd0;
        err = 1'b0;
        for (int p = 3; p >= 0; p--)
        begin
            entry = mhtpc_pkg::TRELLIS_TABLE[{st, symbol[2*p +: 2]}];
            if (entry[3])
            begin
                st     = entry[2:1];
                nib[p] = entry[0];
            end
            else
            begin
                // hold state, leave bit at zero
                err = 1'b1;
            end
        end
        result.next_state = st;
        result.nibble     = nib;
        result.error      = err;
    end

endmodule
